// ===== design/tmpm_pkg.sv =====
`default_nettype none
package tmpm_pkg;

   localparam int MaxNodes = 1024;
   localparam int MaxDepth = 32;
   localparam int MaxText  = 1048576;

   localparam int NodeBits  = $clog2(MaxNodes);
   localparam int CountBits = $clog2(MaxNodes + 1);
   localparam int DepthBits = $clog2(MaxDepth + 1);
   localparam int WinBits   = $clog2(MaxDepth);
   localparam int TextBits  = $clog2(MaxText + 1);
   localparam int PosBits   = 20;
   localparam int QueueDepth = 2;

   typedef logic [1:0] func_type;
   localparam func_type FuncPattern = 2'd0;
   localparam func_type FuncText    = 2'd1;
   localparam func_type FuncEnd     = 2'd2;
   localparam func_type FuncNone    = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [1:0] letter;
      logic       pattern_last;
   } req_type;

   typedef struct packed {
      logic [PosBits-1:0] position;
      logic               is_done;
      logic               overflow;
      logic               last;
   } rsp_type;

   // one trie node: four child links and an end mark
   typedef struct packed {
      logic [3:0][NodeBits-1:0] kid;
      logic                     ends;
   } node_type;

   // classified command passed from front to back
   typedef struct packed {
      logic       is_pattern;
      logic       is_text;
      logic       is_end;
      logic [1:0] letter;
      logic       pattern_last;
   } cmd_type;

endpackage
`default_nettype wire

// ===== design/trie_multi_pattern_matcher.sv =====
// Flow: a word waits in the two-entry queue; in the back end a pattern letter reads
// its node and adds a child link, the last also the end mark; a text letter that
// fills the window starts a walk of up to 32 trie levels, one read per level.
// The back end takes a new word only when done with the last; end of text repeats
// the walk for each start left in the window; rsp_stall holds back any further result.
// Reset: synchronous; a sweep then clears all 1024 node memory words before any word.
`default_nettype none
module trie_multi_pattern_matcher (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tmpm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tmpm_pkg::rsp_type      rsp_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   tmpm_pkg::cmd_type cmd_data;

   tmpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   tmpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== design/tmpm_front.sv =====
`default_nettype none
module tmpm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tmpm_pkg::req_type req_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_pop,
   output tmpm_pkg::cmd_type     cmd_data
);

   localparam int PtrBits = $clog2(tmpm_pkg::QueueDepth);

   tmpm_pkg::cmd_type            queue_ff [tmpm_pkg::QueueDepth];
   logic [PtrBits-1:0]           wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]             count_ff, count_in;
   tmpm_pkg::cmd_type            cmd_new;
   logic                         push, keep;

   // classify the word; func 3 is dropped here
   always_comb begin
      cmd_new.is_pattern   = (req_data.func == tmpm_pkg::FuncPattern);
      cmd_new.is_text      = (req_data.func == tmpm_pkg::FuncText);
      cmd_new.is_end       = (req_data.func == tmpm_pkg::FuncEnd);
      cmd_new.letter       = req_data.letter;
      cmd_new.pattern_last = req_data.pattern_last;
   end

   assign req_stall = (count_ff == (PtrBits+1)'(tmpm_pkg::QueueDepth));
   assign keep      = cmd_new.is_pattern | cmd_new.is_text | cmd_new.is_end;
   assign push      = req_valid & ~req_stall & keep;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // advance pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrBits+1)'(push) - (PtrBits+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

// ===== design/tmpm_back.sv =====
`default_nettype none
module tmpm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_pop,
   input  wire tmpm_pkg::cmd_type cmd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tmpm_pkg::rsp_type      rsp_data
);

   localparam int NB = tmpm_pkg::NodeBits;
   localparam int DB = tmpm_pkg::DepthBits;
   localparam int WB = tmpm_pkg::WinBits;
   localparam int TB = tmpm_pkg::TextBits;
   localparam int MD = tmpm_pkg::MaxDepth;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_IRD    = 10'b0000000100,
      ST_IWR    = 10'b0000001000,
      ST_WREQ   = 10'b0000010000,
      ST_WDAT   = 10'b0000100000,
      ST_EMIT   = 10'b0001000000,
      ST_SHIFT  = 10'b0010000000,
      ST_DONE   = 10'b0100000000,
      ST_ELOOP  = 10'b1000000000
   } state_type;

   state_type                 state_ff, state_in;

   // node memory with child links and end marks
   tmpm_pkg::node_type        mem [tmpm_pkg::MaxNodes];
   tmpm_pkg::node_type        rd_ff;
   logic [NB-1:0]             rd_addr;
   logic                      rd_en;
   logic [NB-1:0]             wr_addr;
   tmpm_pkg::node_type        wr_data;
   logic                      wr_en;
   logic [NB:0]               clr_ff, clr_in;

   logic [tmpm_pkg::CountBits-1:0] node_count_ff, node_count_in;
   logic [NB-1:0]             cursor_ff, cursor_in;
   logic [DB-1:0]             idepth_ff, idepth_in;
   logic                      drop_ff, drop_in;
   logic [1:0]                win_ff [MD];
   logic [1:0]                win_in [MD];
   logic [DB-1:0]             fill_ff, fill_in;
   logic [TB-1:0]             tcount_ff, tcount_in;
   logic                      ovf_ff, ovf_in;

   // walk state
   logic [DB-1:0]             k_ff, k_in;
   logic                      hit_ff, hit_in;
   logic                      is_end_ff, is_end_in;
   tmpm_pkg::cmd_type         cmd_ff, cmd_in;

   logic                      out_full_ff, out_full_in;
   tmpm_pkg::rsp_type         out_ff, out_in;

   logic [NB-1:0]             nxt;
   logic [tmpm_pkg::PosBits-1:0] base;

   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;
   assign nxt       = rd_ff.kid[win_ff[k_ff[WB-1:0]]];
   assign base      = tmpm_pkg::PosBits'(tcount_ff - TB'(fill_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_count_in = node_count_ff;
      cursor_in     = cursor_ff;
      idepth_in     = idepth_ff;
      drop_in       = drop_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      tcount_in     = tcount_ff;
      ovf_in        = ovf_ff;
      k_in          = k_ff;
      hit_in        = hit_ff;
      is_end_in     = is_end_ff;
      cmd_in        = cmd_ff;
      out_full_in   = out_full_ff & rsp_stall;
      out_in        = out_ff;
      cmd_pop       = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      unique case (state_ff)
         // sweep the node memory clear after reset
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[NB-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (NB+1)'(tmpm_pkg::MaxNodes - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take the next word from the queue
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               if (cmd_data.is_pattern) begin
                  rd_en    = 1'b1;
                  rd_addr  = cursor_ff;
                  state_in = ST_IRD;
               end else if (cmd_data.is_text) begin
                  if (tcount_ff >= TB'(tmpm_pkg::MaxText)) begin
                     ovf_in = 1'b1;
                  end else begin
                     if (fill_ff >= DB'(MD)) begin
                        for (int i = 0; i < MD - 1; i++) win_in[i] = win_ff[i+1];
                        win_in[MD-1] = 2'd0;
                        win_in[MD-1] = cmd_data.letter;
                     end else begin
                        win_in[fill_ff[WB-1:0]] = cmd_data.letter;
                        fill_in = fill_ff + 1'b1;
                     end
                     tcount_in = tcount_ff + 1'b1;
                     if (fill_ff >= DB'(MD - 1)) begin
                        is_end_in = 1'b0;
                        state_in  = ST_WREQ;
                     end
                  end
               end else begin
                  is_end_in = 1'b1;
                  state_in  = ST_ELOOP;
               end
            end
         end
         // insert step: memory word of cursor is in rd_ff
         ST_IRD: begin
            state_in = ST_IDLE;
            if (!drop_ff) begin
               if (idepth_ff >= DB'(MD)) begin
                  ovf_in  = 1'b1;
                  drop_in = 1'b1;
               end else if (rd_ff.kid[cmd_ff.letter] != '0) begin
                  cursor_in = rd_ff.kid[cmd_ff.letter];
                  idepth_in = idepth_ff + 1'b1;
               end else if (node_count_ff < tmpm_pkg::CountBits'(tmpm_pkg::MaxNodes)) begin
                  wr_en   = 1'b1;
                  wr_addr = cursor_ff;
                  wr_data = rd_ff;
                  wr_data.kid[cmd_ff.letter] = node_count_ff[NB-1:0];
                  cursor_in     = node_count_ff[NB-1:0];
                  node_count_in = node_count_ff + 1'b1;
                  idepth_in     = idepth_ff + 1'b1;
               end else begin
                  ovf_in  = 1'b1;
                  drop_in = 1'b1;
               end
            end
            if (cmd_ff.pattern_last) begin
               state_in = ST_IWR;
            end
         end
         // close the pattern: mark end on the cursor node
         ST_IWR: begin
            if (!drop_ff && cursor_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = cursor_ff;
               state_in = ST_DONE;
            end else begin
               cursor_in = '0;
               idepth_in = '0;
               drop_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (is_end_ff || !cmd_ff.is_pattern) begin
               // closing item for end of text
               if (!out_full_ff || !rsp_stall) begin
                  out_full_in      = 1'b1;
                  out_in.position  = '0;
                  out_in.is_done   = 1'b1;
                  out_in.overflow  = ovf_ff;
                  out_in.last      = 1'b1;
                  for (int i = 0; i < MD; i++) win_in[i] = 2'd0;
                  fill_in   = '0;
                  tcount_in = '0;
                  is_end_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = cursor_ff;
               wr_data = rd_ff;
               wr_data.ends = 1'b1;
               cursor_in = '0;
               idepth_in = '0;
               drop_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         // start a walk from the root over the window
         ST_WREQ: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            k_in     = '0;
            hit_in   = 1'b0;
            state_in = ST_WDAT;
         end
         // one trie level per read
         ST_WDAT: begin
            if (k_ff >= fill_ff || nxt == '0) begin
               state_in = ST_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = nxt;
               k_in     = k_ff + 1'b1;
               state_in = ST_SHIFT;
            end
         end
         // check end mark of the node just read
         ST_SHIFT: begin
            if (rd_ff.ends) begin
               hit_in   = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_WDAT;
            end
         end
         // report the oldest start if it matched, then drop it
         ST_EMIT: begin
            if (!hit_ff || !out_full_ff || !rsp_stall) begin
               if (hit_ff) begin
                  out_full_in     = 1'b1;
                  out_in.position = base;
                  out_in.is_done  = 1'b0;
                  out_in.overflow = ovf_ff;
                  out_in.last     = ~is_end_ff;
               end
               for (int i = 0; i < MD - 1; i++) win_in[i] = win_ff[i+1];
               win_in[MD-1] = 2'd0;
               fill_in  = fill_ff - 1'b1;
               hit_in   = 1'b0;
               state_in = is_end_ff ? ST_ELOOP : ST_IDLE;
            end
         end
         // end of text: check every start left in the window
         ST_ELOOP: begin
            if (fill_ff != '0) begin
               state_in = ST_WREQ;
            end else begin
               state_in = ST_DONE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         node_count_ff <= tmpm_pkg::CountBits'(1);
         cursor_ff     <= '0;
         idepth_ff     <= '0;
         drop_ff       <= 1'b0;
         fill_ff       <= '0;
         tcount_ff     <= '0;
         ovf_ff        <= 1'b0;
         hit_ff        <= 1'b0;
         is_end_ff     <= 1'b0;
         out_full_ff   <= 1'b0;
         for (int i = 0; i < MD; i++) win_ff[i] <= 2'd0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         node_count_ff <= node_count_in;
         cursor_ff     <= cursor_in;
         idepth_ff     <= idepth_in;
         drop_ff       <= drop_in;
         fill_ff       <= fill_in;
         tcount_ff     <= tcount_in;
         ovf_ff        <= ovf_in;
         hit_ff        <= hit_in;
         is_end_ff     <= is_end_in;
         out_full_ff   <= out_full_in;
         win_ff        <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      cmd_ff  <= cmd_in;
      out_ff  <= out_in;
   end

endmodule
`default_nettype wire

// ===== design/tmpm_checker.sv =====
`default_nettype none
module tmpm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tmpm_pkg::rsp_type rsp_data
);

   // a done word always closes its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_done |-> rsp_data.last)
      else $error("done word without last");

   // done word carries position zero
   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_done |-> rsp_data.position == '0)
      else $error("done word with nonzero position");

   // overflow is sticky across results
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.overflow && !rsp_data.is_done
      |=> !rsp_valid || rsp_data.overflow)
      else $error("overflow flag fell");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind trie_multi_pattern_matcher tmpm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== tb/trie_multi_pattern_matcher_tb.sv =====
`timescale 1ns / 1ps
module trie_multi_pattern_matcher_tb;

   localparam int CycleLimit = 5000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tmpm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tmpm_pkg::rsp_type rsp_data;

   trie_multi_pattern_matcher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow trie and text window
   int unsigned kid_tab [tmpm_pkg::MaxNodes][4];
   bit          end_mark [tmpm_pkg::MaxNodes];
   int unsigned node_total;
   int unsigned cursor;
   int unsigned depth;
   bit          dropping;
   logic [1:0]  window [tmpm_pkg::MaxDepth];
   int unsigned fill;
   int unsigned text_pos;
   bit          ovf;

   tmpm_pkg::req_type pending_words [$];
   tmpm_pkg::rsp_type expected_rsp [$];
   int      errors = 0;
   int      cycles = 0;
   bit      stim_done = 1'b0;
   int      hold_off = 0;

   function automatic bit start_hits(int unsigned len);
      int unsigned node;
      int unsigned nxt;
      node = 0;
      for (int k = 0; k < len && k < tmpm_pkg::MaxDepth; k++) begin
         nxt = kid_tab[node][window[k]];
         if (nxt == 0) return 1'b0;
         if (end_mark[nxt]) return 1'b1;
         node = nxt;
      end
      return 1'b0;
   endfunction

   task automatic shift_window();
      if (fill == 0) return;
      for (int k = 0; k < tmpm_pkg::MaxDepth - 1; k++) window[k] = window[k+1];
      window[tmpm_pkg::MaxDepth-1] = 2'd0;
      fill--;
   endtask

   task automatic add_expected(int unsigned pos, bit done);
      tmpm_pkg::rsp_type r;
      r.position = pos[tmpm_pkg::PosBits-1:0];
      r.is_done = done;
      r.overflow = ovf;
      r.last = 1'b0;
      expected_rsp = {expected_rsp, r};
   endtask

   // compute the results of one accepted word
   task automatic predict_word(tmpm_pkg::req_type w);
      int n;
      int unsigned nxt;
      n = 0;
      case (w.func)
         tmpm_pkg::FuncPattern: begin
            if (!dropping) begin
               if (depth >= tmpm_pkg::MaxDepth) begin
                  ovf = 1'b1;
                  dropping = 1'b1;
               end else begin
                  nxt = kid_tab[cursor][w.letter];
                  if (nxt != 0) begin
                     cursor = nxt;
                     depth++;
                  end else if (node_total < tmpm_pkg::MaxNodes) begin
                     kid_tab[cursor][w.letter] = node_total;
                     cursor = node_total;
                     node_total++;
                     depth++;
                  end else begin
                     ovf = 1'b1;
                     dropping = 1'b1;
                  end
               end
            end
            if (w.pattern_last) begin
               if (!dropping && cursor != 0) end_mark[cursor] = 1'b1;
               cursor = 0;
               depth = 0;
               dropping = 1'b0;
            end
         end
         tmpm_pkg::FuncText: begin
            if (text_pos >= tmpm_pkg::MaxText) begin
               ovf = 1'b1;
            end else begin
               if (fill >= tmpm_pkg::MaxDepth) shift_window();
               window[fill] = w.letter;
               fill++;
               text_pos++;
               if (fill == tmpm_pkg::MaxDepth) begin
                  if (start_hits(fill)) begin
                     add_expected(text_pos - fill, 1'b0);
                     n++;
                  end
                  shift_window();
               end
            end
         end
         tmpm_pkg::FuncEnd: begin
            while (fill > 0) begin
               if (start_hits(fill)) begin
                  add_expected(text_pos - fill, 1'b0);
                  n++;
               end
               shift_window();
            end
            add_expected(0, 1'b1);
            n++;
            for (int k = 0; k < tmpm_pkg::MaxDepth; k++) window[k] = 2'd0;
            text_pos = 0;
         end
         default: ;
      endcase
      if (n > 0) expected_rsp[$].last = 1'b1;
   endtask

   function automatic tmpm_pkg::req_type make_word(logic [1:0] f, logic [1:0] l, logic p);
      tmpm_pkg::req_type w;
      w.func = f;
      w.letter = l;
      w.pattern_last = p;
      return w;
   endfunction

   task automatic add_word(tmpm_pkg::req_type w);
      pending_words = {pending_words, w};
   endtask

   task automatic add_pattern(int len);
      for (int k = 0; k < len; k++)
         add_word(make_word(tmpm_pkg::FuncPattern, 2'($urandom_range(0, 3)),
                            k == len - 1));
   endtask

   // fill the stimulus queue
   initial begin
      int len;
      for (int i = 0; i < tmpm_pkg::MaxNodes; i++) begin
         end_mark[i] = 1'b0;
         for (int j = 0; j < 4; j++) kid_tab[i][j] = 0;
      end
      for (int k = 0; k < tmpm_pkg::MaxDepth; k++) window[k] = 2'd0;
      node_total = 1; cursor = 0; depth = 0; dropping = 0;
      fill = 0; text_pos = 0; ovf = 0;

      // directed: short patterns of every letter, unused selector, text, end
      add_word(make_word(tmpm_pkg::FuncPattern, 2'd0, 1'b1));
      add_word(make_word(tmpm_pkg::FuncPattern, 2'd3, 1'b0));
      add_word(make_word(tmpm_pkg::FuncPattern, 2'd3, 1'b1));
      add_word(make_word(tmpm_pkg::FuncPattern, 2'd1, 1'b0));
      add_word(make_word(tmpm_pkg::FuncPattern, 2'd2, 1'b1));
      add_word(make_word(tmpm_pkg::FuncNone, 2'd3, 1'b1));
      for (int k = 0; k < 6; k++)
         add_word(make_word(tmpm_pkg::FuncText, 2'(k % 4), 1'b0));
      add_word(make_word(tmpm_pkg::FuncEnd, 2'd1, 1'b1));
      add_word(make_word(tmpm_pkg::FuncEnd, 2'd0, 1'b0));

      // random: mostly text with patterns interleaved, some noise
      for (int i = 0; i < 140; i++) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               len = $urandom_range(1, 4);
               add_pattern(len);
               i += len - 1;
            end
            2: add_word(make_word(tmpm_pkg::FuncEnd, 2'($urandom), 1'($urandom)));
            3: add_word(make_word(tmpm_pkg::FuncNone, 2'($urandom), 1'($urandom)));
            default:
               add_word(make_word(tmpm_pkg::FuncText, 2'($urandom_range(0, 3)),
                                  1'($urandom)));
         endcase
      end
      // too-long pattern: overflow after the depth limit
      add_pattern(tmpm_pkg::MaxDepth + 3);
      for (int k = 0; k < 40; k++)
         add_word(make_word(tmpm_pkg::FuncText, 2'($urandom_range(0, 3)), 1'b0));
      add_word(make_word(tmpm_pkg::FuncEnd, 2'd0, 1'b0));
   end

   // drive words with random gaps
   int gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 10) reset <= 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_word(req_data);
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) gap = 0;
         end
         if (!req_valid || !req_stall) begin
            if (gap > 0 || pending_words.size() == 0) begin
               if (gap > 0) gap--;
               req_valid <= 1'b0;
               if (pending_words.size() == 0 && !(req_valid && req_stall))
                  stim_done <= 1'b1;
            end else begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end
         end
      end
   end

   // hold the receiver off once for a long stretch
   bit long_done = 1'b0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!long_done && cycles > 1500) begin
            long_done <= 1'b1;
            hold_off  <= 3000;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
         end
      end
   end

   // check results and stall at random
   int stall_wait = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result position %0d", rsp_data.position);
               errors++;
            end else begin
               tmpm_pkg::rsp_type e;
               e = expected_rsp.pop_front();
               if (e.position !== rsp_data.position) begin
                  $error("position expected %0d actual %0d", e.position, rsp_data.position);
                  errors++;
               end
               if (e.is_done !== rsp_data.is_done) begin
                  $error("is_done expected %0d actual %0d", e.is_done, rsp_data.is_done);
                  errors++;
               end
               if (e.overflow !== rsp_data.overflow) begin
                  $error("overflow expected %0d actual %0d", e.overflow, rsp_data.overflow);
                  errors++;
               end
               if (e.last !== rsp_data.last) begin
                  $error("last expected %0d actual %0d", e.last, rsp_data.last);
                  errors++;
               end
            end
            stall_wait = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) stall_wait = 0;
         end
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_wait > 0) begin
            stall_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // finish once everything drained
   initial begin
      wait (stim_done && expected_rsp.size() == 0 && hold_off == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      wait (cycles >= CycleLimit);
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== sim.f =====
design/tmpm_pkg.sv
design/tmpm_front.sv
design/tmpm_back.sv
design/trie_multi_pattern_matcher.sv
design/tmpm_checker.sv
tb/trie_multi_pattern_matcher_tb.sv
